/* design/urt_pkg.sv */
// Shared types and constants of the ultrasonic range tracker.
// No dependencies; the module files refer to it by scoped names.
package urt_pkg;

    // Configuration port geometry and register indexes
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    typedef enum logic
    {
        REG_LOST_LIMIT = 1'b0,
        REG_MAX_DIST   = 1'b1
    } reg_idx_t;

    localparam logic [6:0] LOST_LIMIT_RST = 7'd5;
    localparam logic [9:0] MAX_DIST_RST   = 10'd200;

    // Echo width to centimeters: divide by 59 via reciprocal 71090 / 2^22,
    // exact for widths below 2^16
    localparam logic [5:0]  US_PER_CM   = 6'd59;
    localparam logic [16:0] RECIP_59    = 17'd71090;
    localparam int unsigned RECIP_SHIFT = 22;

    // Field and internal widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SPAN_W  = 16;
    localparam int unsigned DIST_W  = 10;
    localparam int unsigned Q8_W    = 18;
    localparam int unsigned LIMIT_W = 7;
    localparam int unsigned LOST_W  = 8;
    localparam int unsigned ACC_W   = 27;

    // Smoothing weights 0.6 / 0.4 in Q.8 and the half-up rounding term
    localparam logic [7:0] W_OLD     = 8'd154;
    localparam logic [7:0] W_NEW     = 8'd102;
    localparam logic [7:0] ROUND_Q8  = 8'd128;
    localparam logic [7:0] LOST_MAX  = 8'd255;

    typedef enum logic [1:0]
    {
        OP_EDGE   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_TICK   = 2'd2
    } op_t;

    // Classified item, front to back through the queue
    typedef struct packed
    {
        op_t               op;
        logic [SPAN_W-1:0] width;
        logic [DIST_W-1:0] vis_alt;
    } item_t;

    // Item after the distance stage of the back end
    typedef struct packed
    {
        op_t               op;
        logic [DIST_W-1:0] dist_cm;
        logic [DIST_W-1:0] vis_alt;
    } stage_t;

endpackage

/* design/urt_event_if.sv */
// Input channel of the range tracker: echo edges and update ticks.
// Depends on nothing; widths match the fields in urt_pkg.
interface urt_event_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        echo_level;
    logic [31:0] time_us;
    logic        vision_ok;
    logic [9:0]  vision_altitude_cm;

    modport source
    (
        output valid, kind, echo_level, time_us, vision_ok, vision_altitude_cm,
        input  ready
    );

    modport sink
    (
        input  valid, kind, echo_level, time_us, vision_ok, vision_altitude_cm,
        output ready
    );
endinterface

/* design/urt_result_if.sv */
// Output channel of the range tracker: one result beat per input beat.
// Depends on nothing; widths match the fields in urt_pkg.
interface urt_result_if;
    logic        valid;
    logic        ready;
    logic [17:0] altitude_q8;
    logic        available;
    logic        fire_trigger;
    logic        new_sample;

    modport source
    (
        output valid, altitude_q8, available, fire_trigger, new_sample,
        input  ready
    );

    modport sink
    (
        input  valid, altitude_q8, available, fire_trigger, new_sample,
        output ready
    );
endinterface

/* design/urt_front.sv */
// Front end: accepts input beats, tracks the echo start time and classifies.
// Depends on urt_pkg and urt_event_if.
module urt_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    urt_event_if.sink                  event_ch,
    input  logic [urt_pkg::SPAN_W-1:0] span,
    input  logic                       q_full,
    output logic                       push,
    output urt_pkg::item_t             item
);

    logic [urt_pkg::TIME_W-1:0] start_reg;
    logic [urt_pkg::TIME_W-1:0] start_next;
    logic [urt_pkg::TIME_W:0]   diff;
    logic                       later;
    logic                       in_range;

    // Take a beat whenever the queue has room
    assign event_ch.ready = !q_full;
    assign push           = event_ch.valid && !q_full;

    // Width of the pulse; a borrow means stop came before start
    assign diff     = {1'b0, event_ch.time_us} - {1'b0, start_reg};
    assign later    = !diff[urt_pkg::TIME_W] && (diff[urt_pkg::TIME_W-1:0] != '0);
    // Distance in (0, max) is width in [59, 59*max)
    assign in_range = (diff[urt_pkg::TIME_W-1:0] >= {26'b0, urt_pkg::US_PER_CM})
                   && (diff[urt_pkg::TIME_W-1:0] < {16'b0, span});

    // Classify the beat
    always_comb
    begin
        item.width   = diff[urt_pkg::SPAN_W-1:0];
        item.vis_alt = event_ch.vision_ok ? event_ch.vision_altitude_cm : '0;
        if (event_ch.kind)
        begin
            item.op = urt_pkg::OP_TICK;
        end
        else if (!event_ch.echo_level && later && in_range)
        begin
            item.op = urt_pkg::OP_SAMPLE;
        end
        else
        begin
            item.op = urt_pkg::OP_EDGE;
        end
    end

    // Record the start time on a rising edge
    always_comb
    begin
        start_next = start_reg;
        if (push && !event_ch.kind && event_ch.echo_level)
        begin
            start_next = event_ch.time_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else
        begin
            start_reg <= start_next;
        end
    end

endmodule

/* design/urt_queue.sv */
// Short queue between front and back end of the range tracker.
// Depends on urt_pkg for the item type.
module urt_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  urt_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output urt_pkg::item_t head_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    urt_pkg::item_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* design/urt_back.sv */
// Back end: converts widths to distance, runs the estimate and lost-echo
// state, and holds the result register. Depends on urt_pkg, urt_result_if.
module urt_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  urt_pkg::item_t              q_item,
    output logic                        pop,
    input  logic [urt_pkg::LIMIT_W-1:0] lost_limit,
    urt_result_if.source                result_ch
);

    localparam int unsigned PROD_W = urt_pkg::SPAN_W + 17;

    // Distance stage
    logic                         a_valid_reg;
    urt_pkg::stage_t              a_reg;
    logic                         a_ready;
    logic [PROD_W-1:0]            prod;

    // Estimate state
    logic [urt_pkg::Q8_W-1:0]     cur_reg;
    logic [urt_pkg::Q8_W-1:0]     cur_next;
    logic [urt_pkg::Q8_W-1:0]     smooth_reg;
    logic [urt_pkg::Q8_W-1:0]     smooth_next;
    logic [urt_pkg::LOST_W-1:0]   lost_reg;
    logic [urt_pkg::LOST_W-1:0]   lost_next;
    logic                         avail_reg;
    logic                         avail_next;

    // Result register
    logic                         out_valid_reg;
    logic                         fire_reg;
    logic                         fresh_reg;
    logic                         out_free;
    logic                         a_adv;

    logic [urt_pkg::LOST_W-1:0]   twice;
    logic                         lost_below;
    logic [urt_pkg::Q8_W-1:0]     cur_sel;
    logic [urt_pkg::ACC_W-1:0]    acc;

    // Handshake chain: result register, then distance stage, then queue
    assign out_free = !out_valid_reg || result_ch.ready;
    assign a_ready  = !a_valid_reg || out_free;
    assign a_adv    = a_valid_reg && out_free;
    assign pop      = q_valid && a_ready;

    // Divide the width by 59 through the reciprocal
    assign prod = {{(PROD_W-urt_pkg::SPAN_W){1'b0}}, q_item.width}
                * {{(PROD_W-17){1'b0}}, urt_pkg::RECIP_59};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_reg.op      <= q_item.op;
            a_reg.vis_alt <= q_item.vis_alt;
            a_reg.dist_cm <= prod[urt_pkg::RECIP_SHIFT +: urt_pkg::DIST_W];
        end
    end

    // Update estimate and lost counter for the item in the distance stage
    assign twice      = {lost_limit, 1'b0};
    assign lost_below = lost_reg < {1'b0, lost_limit};
    assign cur_sel    = (!lost_below && (a_reg.vis_alt != '0))
                      ? {a_reg.vis_alt, 8'b0} : cur_reg;
    assign acc = {{(urt_pkg::ACC_W-urt_pkg::Q8_W){1'b0}}, smooth_reg}
                   * {{(urt_pkg::ACC_W-8){1'b0}}, urt_pkg::W_OLD}
               + {{(urt_pkg::ACC_W-urt_pkg::Q8_W){1'b0}}, cur_sel}
                   * {{(urt_pkg::ACC_W-8){1'b0}}, urt_pkg::W_NEW}
               + {{(urt_pkg::ACC_W-8){1'b0}}, urt_pkg::ROUND_Q8};

    always_comb
    begin
        cur_next    = cur_reg;
        smooth_next = smooth_reg;
        lost_next   = lost_reg;
        avail_next  = avail_reg;
        unique case (a_reg.op)
            urt_pkg::OP_SAMPLE:
            begin
                cur_next = {a_reg.dist_cm, 8'b0};
                // Ease the lost counter
                if (lost_reg > twice)
                begin
                    lost_next = (twice != '0) ? twice - 1'b1 : '0;
                end
                else if (lost_reg >= {1'b0, lost_limit})
                begin
                    lost_next = (lost_reg > 8'd2) ? lost_reg - 8'd2 : '0;
                end
                else
                begin
                    lost_next = '0;
                end
            end
            urt_pkg::OP_TICK:
            begin
                avail_next  = lost_below || (a_reg.vis_alt != '0);
                lost_next   = (lost_reg != urt_pkg::LOST_MAX) ? lost_reg + 1'b1 : lost_reg;
                smooth_next = acc[8 +: urt_pkg::Q8_W];
                cur_next    = acc[8 +: urt_pkg::Q8_W];
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            smooth_reg    <= '0;
            lost_reg      <= '0;
            avail_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= a_valid_reg;
            end
            if (a_adv)
            begin
                cur_reg    <= cur_next;
                smooth_reg <= smooth_next;
                lost_reg   <= lost_next;
                avail_reg  <= avail_next;
            end
        end
    end

    // Hold the flags of the result beat
    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            fire_reg  <= (a_reg.op == urt_pkg::OP_TICK);
            fresh_reg <= (a_reg.op == urt_pkg::OP_SAMPLE);
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.altitude_q8  = cur_reg;
    assign result_ch.available    = avail_reg;
    assign result_ch.fire_trigger = fire_reg;
    assign result_ch.new_sample   = fresh_reg;

endmodule

/* design/ultrasonic_range_tracker.sv */
// Ultrasonic range tracker: echo edges and update ticks in, one result
// beat out per input beat. Uses urt_pkg, urt_event_if, urt_result_if,
// urt_front, urt_queue and urt_back.
//
// event_ch carries echo edges (kind 0) with a microsecond timestamp and
// update ticks (kind 1) with the vision altitude. result_ch returns the
// altitude in Q10.8 cm, the available flag, fire_trigger on ticks and
// new_sample on falling edges that gave a valid distance.
// Throughput is one beat per cycle while result_ch is ready. A result
// passes from the queue through the distance stage (a 16x17 reciprocal
// multiply) into the result register.
// When result_ch stalls, the result register holds, the distance stage
// fills, and the queue (QUEUE_DEPTH entries) absorbs input until full;
// event_ch.ready falls only when the queue is full.
// Reset clears the estimate, start time, queue and valid flags, and loads
// lost_limit = 5 and max_distance_cm = 200. Registers sit on the APB port:
// lost_limit at 0x0, max_distance_cm at 0x4; write them only when idle.
module ultrasonic_range_tracker
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    urt_event_if.sink                  event_ch,
    urt_result_if.source               result_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [urt_pkg::ADDR_W-1:0] paddr,
    input  logic [urt_pkg::DATA_W-1:0] pwdata,
    output logic [urt_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [urt_pkg::LIMIT_W-1:0] lost_limit_reg;
    logic [urt_pkg::DIST_W-1:0]  max_dist_reg;
    logic [urt_pkg::SPAN_W-1:0]  span_reg;
    logic                        wr_en;
    urt_pkg::reg_idx_t           reg_idx;

    logic           push;
    logic           q_full;
    logic           pop;
    logic           q_valid;
    urt_pkg::item_t push_item;
    urt_pkg::item_t head_item;

    // Configuration registers; span keeps 59 * max_distance_cm
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = urt_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lost_limit_reg <= urt_pkg::LOST_LIMIT_RST;
            max_dist_reg   <= urt_pkg::MAX_DIST_RST;
            span_reg       <= {6'b0, urt_pkg::MAX_DIST_RST} * {10'b0, urt_pkg::US_PER_CM};
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                urt_pkg::REG_LOST_LIMIT:
                begin
                    lost_limit_reg <= pwdata[urt_pkg::LIMIT_W-1:0];
                end
                urt_pkg::REG_MAX_DIST:
                begin
                    max_dist_reg <= pwdata[urt_pkg::DIST_W-1:0];
                    span_reg     <= {6'b0, pwdata[urt_pkg::DIST_W-1:0]}
                                  * {10'b0, urt_pkg::US_PER_CM};
                end
                default:
                begin
                    max_dist_reg <= max_dist_reg;
                end
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        unique case (reg_idx)
            urt_pkg::REG_LOST_LIMIT: prdata = {25'b0, lost_limit_reg};
            urt_pkg::REG_MAX_DIST:   prdata = {22'b0, max_dist_reg};
            default:                 prdata = '0;
        endcase
    end

    urt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .event_ch (event_ch),
        .span     (span_reg),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    urt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    urt_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (head_item),
        .pop        (pop),
        .lost_limit (lost_limit_reg),
        .result_ch  (result_ch)
    );

endmodule
